// ===== design/bcv_pkg.sv =====
// Shared types and constants of the cubic Bezier curve engine.
// Used by the request interface, the weight unit, the accumulator lanes and the top level.
// No dependencies.
package bcv_pkg;

  typedef enum logic [2:0] {
    OP_MOVE = 3'd0,
    OP_READ = 3'd1,
    OP_POS  = 3'd2,
    OP_VEL  = 3'd3,
    OP_TESS = 3'd4
  } op_e;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_T     = 1'b1;

  localparam logic [4:0] SEG_COUNT_RST = 5'd1;
  localparam logic [6:0] RES_T_RST     = 7'd16;
  localparam logic [6:0] MAX_POINTS    = 7'd64;

  localparam int IN_W      = 16;
  localparam int T_W       = 16;
  localparam int W_W       = 25;
  localparam int POS_SHIFT = 24;
  localparam int VEL_SHIFT = 16;

  typedef struct packed {
    logic start;
    logic vel;
  } wgt_ctrl_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic vel;
  } mac_ctrl_t;

endpackage

// ===== design/bcv_if.sv =====
// Request and response channels of the cubic Bezier curve engine.
// Depends on bcv_pkg for the field widths.
interface bcv_req_if import bcv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             opcode;
  logic [3:0]             segment;
  logic [1:0]             point_index;
  logic                   keep_smooth;
  logic [T_W-1:0]         t;
  logic signed [IN_W-1:0] new_x;
  logic signed [IN_W-1:0] new_y;
  logic signed [IN_W-1:0] new_z;

  modport source (output valid, opcode, segment, point_index, keep_smooth, t,
                  new_x, new_y, new_z, input ready);
  modport sink (input valid, opcode, segment, point_index, keep_smooth, t,
                new_x, new_y, new_z, output ready);
endinterface

interface bcv_rsp_if #(parameter int CW = 16) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic                 last;
  logic                 status;

  modport source (output valid, out_x, out_y, out_z, last, status, input ready);
  modport sink (input valid, out_x, out_y, out_z, last, status, output ready);
endinterface

// ===== design/bcv_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bcv_ram #(
  parameter int WIDTH  = 48,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/bcv_wgt.sv =====
// Basis weight unit: one shared 34x17 multiplier, used in turn for every product.
// Gives the four Bernstein weights (Q1.24) or the three derivative weights (Q2.16).
// Depends on bcv_pkg.
module bcv_wgt import bcv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wgt_ctrl_t             ctrl_i,
  input  logic [T_W-1:0]        t_i,
  output logic                  done_o,
  output logic [3:0][W_W-1:0]   w_o
);

  logic              busy_q, done_q, vel_q;
  logic [2:0]        cyc_q;
  logic [16:0]       u_q, tv_q;
  logic [50:0]       prod_q;
  logic [33:0]       uu_q, tt_q, ut_q;
  logic [3:0][W_W-1:0] pw_q;
  logic [33:0]       opa;
  logic [16:0]       opb;
  logic [52:0]       prod3;
  logic [34:0]       v_uu3, v_tt3;
  logic [36:0]       v_ut6;

  always_comb begin
    opa = '0;
    opb = '0;
    case (cyc_q)
      3'd0: begin opa = 34'(u_q);  opb = u_q;  end
      3'd1: begin opa = 34'(tv_q); opb = tv_q; end
      3'd2: begin opa = 34'(u_q);  opb = tv_q; end
      3'd3: begin opa = uu_q;      opb = u_q;  end
      3'd4: begin opa = uu_q;      opb = tv_q; end
      3'd5: begin opa = tt_q;      opb = u_q;  end
      3'd6: begin opa = tt_q;      opb = tv_q; end
      default: ;
    endcase
  end

  assign prod3 = 53'(prod_q) + (53'(prod_q) << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      vel_q  <= 1'b0;
      cyc_q  <= '0;
    end else begin
      done_q <= busy_q && (cyc_q == 3'd7);
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cyc_q  <= '0;
        vel_q  <= ctrl_i.vel;
      end else if (busy_q) begin
        cyc_q <= cyc_q + 3'd1;
        if (cyc_q == 3'd7) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Multiply in step n, store the product of step n-1.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      u_q  <= 17'h10000 - 17'(t_i);
      tv_q <= 17'(t_i);
    end
    if (busy_q) begin
      if (cyc_q != 3'd7) begin
        prod_q <= 51'(opa) * 51'(opb);
      end
      case (cyc_q)
        3'd1: uu_q <= prod_q[33:0];
        3'd2: tt_q <= prod_q[33:0];
        3'd3: ut_q <= prod_q[33:0];
        3'd4: pw_q[0] <= W_W'(prod_q >> POS_SHIFT);
        3'd5: pw_q[1] <= W_W'(prod3 >> POS_SHIFT);
        3'd6: pw_q[2] <= W_W'(prod3 >> POS_SHIFT);
        3'd7: pw_q[3] <= W_W'(prod_q >> POS_SHIFT);
        default: ;
      endcase
    end
  end

  // Derivative weights 3u^2, 6ut, 3t^2, placed on the upper point of each difference.
  assign v_uu3 = 35'(uu_q) + (35'(uu_q) << 1);
  assign v_ut6 = (37'(ut_q) << 2) + (37'(ut_q) << 1);
  assign v_tt3 = 35'(tt_q) + (35'(tt_q) << 1);

  always_comb begin
    if (vel_q) begin
      w_o[0] = '0;
      w_o[1] = W_W'(v_uu3 >> VEL_SHIFT);
      w_o[2] = W_W'(v_ut6 >> VEL_SHIFT);
      w_o[3] = W_W'(v_tt3 >> VEL_SHIFT);
    end else begin
      w_o = pw_q;
    end
  end

  assign done_o = done_q;

endmodule

// ===== design/bcv_mac.sv =====
// Three accumulator lanes (x, y, z): weight times point or point difference,
// registered product, then accumulate; rounds and saturates the sums.
// Depends on bcv_pkg.
module bcv_mac import bcv_pkg::*; #(
  parameter int CW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mac_ctrl_t       ctrl_i,
  input  logic [W_W-1:0]  w_i,
  input  logic [3*CW-1:0] pt_i,
  output logic [3*CW-1:0] res_o
);

  localparam int PW    = W_W + CW + 2;
  localparam int ACC_W = CW + 28;
  localparam logic signed [ACC_W:0] HALF_P = (ACC_W+1)'(1) <<< (POS_SHIFT - 1);
  localparam logic signed [ACC_W:0] HALF_V = (ACC_W+1)'(1) <<< (VEL_SHIFT - 1);
  localparam logic signed [ACC_W:0] SMAX = ((ACC_W+1)'(1) <<< (CW - 1)) - 1;
  localparam logic signed [ACC_W:0] SMIN = -SMAX - 1;

  logic                    en_q;
  logic signed [CW-1:0]    pt    [3];
  logic signed [CW-1:0]    prev_q[3];
  logic signed [CW:0]      opnd  [3];
  logic signed [PW-1:0]    prod_q[3];
  logic signed [ACC_W-1:0] acc_q [3];
  logic signed [ACC_W:0]   rnd   [3];
  logic signed [ACC_W:0]   shv   [3];
  logic signed [W_W:0]     wext;

  assign wext = signed'({1'b0, w_i});

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pt[a]   = signed'(pt_i[a*CW +: CW]);
      opnd[a] = ctrl_i.vel ? ((CW+1)'(pt[a]) - (CW+1)'(prev_q[a])) : (CW+1)'(pt[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= ctrl_i.en && !ctrl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (ctrl_i.clr) begin
        acc_q[a]  <= '0;
        prev_q[a] <= '0;
      end else begin
        if (ctrl_i.en) begin
          prev_q[a] <= pt[a];
          prod_q[a] <= PW'(wext) * PW'(opnd[a]);
        end
        if (en_q) begin
          acc_q[a] <= acc_q[a] + ACC_W'(prod_q[a]);
        end
      end
    end
  end

  // Round half up, then clamp to the coordinate range.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rnd[a] = (ACC_W+1)'(acc_q[a]) + (ctrl_i.vel ? HALF_V : HALF_P);
      shv[a] = ctrl_i.vel ? (rnd[a] >>> VEL_SHIFT) : (rnd[a] >>> POS_SHIFT);
      if (shv[a] > SMAX) begin
        res_o[a*CW +: CW] = SMAX[CW-1:0];
      end else if (shv[a] < SMIN) begin
        res_o[a*CW +: CW] = SMIN[CW-1:0];
      end else begin
        res_o[a*CW +: CW] = shv[a][CW-1:0];
      end
    end
  end

endmodule

// ===== design/cubic_bezier_curve_engine_top.sv =====
// Top level of the cubic Bezier curve engine: sequencer, control point memory,
// weight unit and accumulator lanes. Depends on bcv_pkg, bcv_if, bcv_ram, bcv_wgt, bcv_mac.

// The block holds the control points of up to MAX_SEGMENTS cubic segments in one
// synchronous RAM (one point per word) and handles one request at a time. After
// reset a clearing pass zeroes every RAM word while no request is taken. A read
// passes through a RAM read and a capture of its data; a move runs a chain of
// read-modify-write steps on the one RAM. Position and velocity run the weight
// unit (one shared multiplier used in turn for each product), then read the
// segment's four points from the RAM and finish the products and sums. Tessellation
// first runs a bit-serial division of 65536 by the point count, then evaluates each
// point as a position. A finished result waits in the output register while the
// next request is taken.
module cubic_bezier_curve_engine_top import bcv_pkg::*; #(
  parameter int MAX_SEGMENTS = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bcv_req_if.sink               req,
  bcv_rsp_if.source             rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW    = COORD_WIDTH;
  localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int AW    = SEG_W + 2;
  localparam int DW    = 3 * CW;
  localparam int XW    = CW + 2;
  localparam int IW    = (XW > 17) ? XW : 17;
  localparam logic signed [XW-1:0] CMAX_X = (XW'(1) <<< (CW - 1)) - 1;
  localparam logic signed [XW-1:0] CMIN_X = -CMAX_X - 1;
  localparam logic [4:0] CNT_CAP = (MAX_SEGMENTS > 31) ? 5'd31 : 5'(MAX_SEGMENTS);

  typedef enum logic [15:0] {
    S_CLEAR  = 16'h0001,
    S_IDLE   = 16'h0002,
    S_MV_RD  = 16'h0004,
    S_MV_WR  = 16'h0008,
    S_MV_JN  = 16'h0010,
    S_MV_R1  = 16'h0020,
    S_MV_W1  = 16'h0040,
    S_MV_R2  = 16'h0080,
    S_MV_W2  = 16'h0100,
    S_RD_CAP = 16'h0200,
    S_DIV    = 16'h0400,
    S_WGO    = 16'h0800,
    S_WGT    = 16'h1000,
    S_PT     = 16'h2000,
    S_DRAIN  = 16'h4000,
    S_OUT    = 16'h8000
  } state_e;

  function automatic logic signed [CW-1:0] sat_c(input logic signed [XW-1:0] v);
    if (v > CMAX_X) return CMAX_X[CW-1:0];
    if (v < CMIN_X) return CMIN_X[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_in(input logic signed [IN_W-1:0] v);
    logic signed [IW-1:0] ve;
    ve = IW'(v);
    if (ve > IW'(CMAX_X)) return CMAX_X[CW-1:0];
    if (ve < IW'(CMIN_X)) return CMIN_X[CW-1:0];
    return ve[CW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [4:0] s, input logic [1:0] i);
    return {SEG_W'(s), i};
  endfunction

  state_e              state_q;
  logic [4:0]          seg_count_q, cnt_eff;
  logic [6:0]          res_t_q;
  op_e                 op_q;
  logic [3:0]          seg_q;
  logic [1:0]          idx_q;
  logic                smooth_q;
  logic [DW-1:0]       np_q;
  logic signed [CW:0]  d_q [3];
  logic [AW-1:0]       clr_addr_q;
  logic [1:0]          pt_cnt_q, rd_idx_q, drain_q;
  logic                rd_vld_q;
  logic [DW-1:0]       res_q;
  logic                res_last_q, res_stat_q;
  logic                ovalid_q, olast_q, ostat_q;
  logic [DW-1:0]       odata_q;
  logic [6:0]          n_q, k_q, trem_q, r0_q;
  logic [16:0]         tk_q, q0_q;
  logic [4:0]          div_cnt_q;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [DW-1:0]       ram_wdata, ram_rdata;
  logic [DW-1:0]       a_data, add_data;
  logic signed [CW-1:0] lane_old [3];
  logic signed [CW-1:0] lane_np  [3];
  logic signed [CW-1:0] lane_add [3];
  logic signed [CW-1:0] lane_mir [3];

  logic [4:0]          sm1, sp1, seg5;
  logic                last_seg, smooth_en, jn_en, mirror_mode, b_need;
  logic [AW-1:0]       tgt_addr, jn_addr, a_raddr, a_waddr, b_addr;
  logic                accept, seg_bad, out_load, wdone;
  logic [7:0]          div_rs, tsum;
  logic                div_ge;
  logic [6:0]          n_eff;
  logic [3:0][W_W-1:0] wts;
  logic [DW-1:0]       mac_res;
  wgt_ctrl_t           wctrl;
  mac_ctrl_t           mctrl;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= SEG_COUNT_RST;
      res_t_q     <= RES_T_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEG_COUNT: seg_count_q <= cfg_data_i[4:0];
        CFG_RES_T:     res_t_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cnt_eff = (seg_count_q > CNT_CAP) ? CNT_CAP : seg_count_q;
  assign n_eff   = (res_t_q == 7'd0) ? 7'd1 : ((res_t_q > MAX_POINTS) ? MAX_POINTS : res_t_q);

  assign req.ready = (state_q == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign seg_bad   = ({1'b0, req.segment} >= cnt_eff);

  // Neighbor addresses for a move
  assign seg5     = {1'b0, seg_q};
  assign sm1      = seg5 - 5'd1;
  assign sp1      = seg5 + 5'd1;
  assign last_seg = (sp1 == cnt_eff);
  assign tgt_addr = addr_of(seg5, idx_q);
  assign smooth_en = smooth_q && !((seg_q == 4'd0) && (idx_q < 2'd2))
                     && !(last_seg && (idx_q > 2'd1));
  assign jn_en    = ((idx_q == 2'd0) && (seg_q != 4'd0)) || ((idx_q == 2'd3) && !last_seg);
  assign jn_addr  = (idx_q == 2'd0) ? addr_of(sm1, 2'd3) : addr_of(sp1, 2'd0);
  assign mirror_mode = (idx_q == 2'd1) || (idx_q == 2'd2);
  assign b_need   = (idx_q == 2'd0) || (idx_q == 2'd3);
  assign b_addr   = (idx_q == 2'd0) ? addr_of(seg5, 2'd1) : addr_of(seg5, 2'd2);

  always_comb begin
    case (idx_q)
      2'd0: begin a_raddr = addr_of(sm1, 2'd2);  a_waddr = addr_of(sm1, 2'd2); end
      2'd1: begin a_raddr = addr_of(sm1, 2'd3);  a_waddr = addr_of(sm1, 2'd2); end
      2'd2: begin a_raddr = addr_of(seg5, 2'd3); a_waddr = addr_of(sp1, 2'd1); end
      default: begin a_raddr = addr_of(sp1, 2'd1); a_waddr = addr_of(sp1, 2'd1); end
    endcase
  end

  // Per-axis shift by the move distance, or mirror about the joint
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lane_old[a] = signed'(ram_rdata[a*CW +: CW]);
      lane_np[a]  = signed'(np_q[a*CW +: CW]);
      lane_add[a] = sat_c(XW'(lane_old[a]) + XW'(d_q[a]));
      lane_mir[a] = sat_c((XW'(lane_old[a]) <<< 1) - XW'(lane_np[a]));
      add_data[a*CW +: CW] = lane_add[a];
      a_data[a*CW +: CW]   = mirror_mode ? lane_mir[a] : lane_add[a];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tgt_addr;
    ram_wdata = np_q;
    ram_raddr = tgt_addr;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      S_MV_WR: ram_we = 1'b1;
      S_MV_JN: begin
        ram_we    = jn_en;
        ram_waddr = jn_addr;
      end
      S_MV_R1: ram_raddr = a_raddr;
      S_MV_W1: begin
        ram_we    = smooth_en;
        ram_waddr = a_waddr;
        ram_wdata = a_data;
      end
      S_MV_R2: ram_raddr = b_addr;
      S_MV_W2: begin
        ram_we    = smooth_en && b_need;
        ram_waddr = b_addr;
        ram_wdata = add_data;
      end
      S_PT: ram_raddr = addr_of(seg5, pt_cnt_q);
      default: ;
    endcase
  end

  bcv_ram #(
    .WIDTH (DW),
    .ADDR_W(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign wctrl = '{start: (state_q == S_WGO), vel: (op_q == OP_VEL)};
  assign mctrl = '{clr: (state_q == S_WGO), en: rd_vld_q, vel: (op_q == OP_VEL)};

  bcv_wgt u_wgt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(wctrl),
    .t_i   (tk_q[T_W-1:0]),
    .done_o(wdone),
    .w_o   (wts)
  );

  bcv_mac #(
    .CW(CW)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mctrl),
    .w_i   (wts[rd_idx_q]),
    .pt_i  (ram_rdata),
    .res_o (mac_res)
  );

  // Restoring division of 65536 by the point count, one quotient bit a cycle
  assign div_rs = {r0_q, (div_cnt_q == 5'd16)};
  assign div_ge = (div_rs >= {1'b0, n_q});
  assign tsum   = {1'b0, trem_q} + {1'b0, r0_q};

  assign out_load = (state_q == S_OUT) && (!ovalid_q || rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      rd_vld_q   <= 1'b0;
      ovalid_q   <= 1'b0;
      op_q       <= OP_READ;
      pt_cnt_q   <= '0;
      drain_q    <= '0;
      div_cnt_q  <= '0;
    end else begin
      rd_vld_q <= (state_q == S_PT);
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (rsp.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == {AW{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (req.opcode <= OP_TESS)) begin
            op_q <= op_e'(req.opcode);
            if (seg_bad) begin
              state_q <= S_OUT;
            end else begin
              case (req.opcode)
                OP_MOVE, OP_READ: state_q <= S_MV_RD;
                OP_TESS: begin
                  state_q   <= S_DIV;
                  div_cnt_q <= 5'd16;
                end
                default: state_q <= S_WGO;
              endcase
            end
          end
        end
        S_MV_RD: state_q <= (op_q == OP_MOVE) ? S_MV_WR : S_RD_CAP;
        S_MV_WR: state_q <= S_MV_JN;
        S_MV_JN: state_q <= S_MV_R1;
        S_MV_R1: state_q <= S_MV_W1;
        S_MV_W1: state_q <= S_MV_R2;
        S_MV_R2: state_q <= S_MV_W2;
        S_MV_W2: state_q <= S_OUT;
        S_RD_CAP: state_q <= S_OUT;
        S_DIV: begin
          div_cnt_q <= div_cnt_q - 5'd1;
          if (div_cnt_q == 5'd0) begin
            state_q <= S_WGO;
          end
        end
        S_WGO: state_q <= S_WGT;
        S_WGT: begin
          if (wdone) begin
            state_q  <= S_PT;
            pt_cnt_q <= '0;
          end
        end
        S_PT: begin
          pt_cnt_q <= pt_cnt_q + 2'd1;
          if (pt_cnt_q == 2'd3) begin
            state_q <= S_DRAIN;
            drain_q <= '0;
          end
        end
        S_DRAIN: begin
          drain_q <= drain_q + 2'd1;
          if (drain_q == 2'd2) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= (op_q == OP_TESS && !res_last_q) ? S_WGO : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Request fields, move scratch, tessellation counters and results
  always_ff @(posedge clk_i) begin
    rd_idx_q <= pt_cnt_q;
    if (accept) begin
      seg_q    <= req.segment;
      idx_q    <= req.point_index;
      smooth_q <= req.keep_smooth;
      np_q     <= {sat_in(req.new_z), sat_in(req.new_y), sat_in(req.new_x)};
      // tessellation starts from t = 0
      tk_q     <= (req.opcode == OP_TESS) ? 17'd0 : {1'b0, req.t};
      n_q      <= n_eff;
      k_q      <= '0;
      trem_q   <= '0;
      q0_q     <= '0;
      r0_q     <= '0;
      res_q      <= '0;
      res_last_q <= 1'b1;
      res_stat_q <= seg_bad;
    end
    case (state_q)
      S_MV_WR: begin
        for (int a = 0; a < 3; a++) begin
          d_q[a] <= (CW+1)'(lane_np[a]) - (CW+1)'(lane_old[a]);
        end
        res_q      <= np_q;
        res_last_q <= 1'b1;
        res_stat_q <= 1'b0;
      end
      S_RD_CAP: begin
        res_q      <= ram_rdata;
        res_last_q <= 1'b1;
        res_stat_q <= 1'b0;
      end
      S_DIV: begin
        r0_q <= div_ge ? 7'(div_rs - {1'b0, n_q}) : div_rs[6:0];
        q0_q <= {q0_q[15:0], div_ge};
      end
      S_DRAIN: begin
        if (drain_q == 2'd2) begin
          res_q      <= mac_res;
          res_last_q <= (op_q != OP_TESS) || ((k_q + 7'd1) == n_q);
          res_stat_q <= 1'b0;
        end
      end
      S_OUT: begin
        // advance to the next tessellation point: t += floor(65536/n) plus carry
        if (out_load && op_q == OP_TESS && !res_last_q) begin
          k_q <= k_q + 7'd1;
          if (tsum >= {1'b0, n_q}) begin
            trem_q <= 7'(tsum - {1'b0, n_q});
            tk_q   <= tk_q + q0_q + 17'd1;
          end else begin
            trem_q <= tsum[6:0];
            tk_q   <= tk_q + q0_q;
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      odata_q <= res_q;
      olast_q <= res_last_q;
      ostat_q <= res_stat_q;
    end
  end

  assign rsp.valid  = ovalid_q;
  assign rsp.out_x  = odata_q[0*CW +: CW];
  assign rsp.out_y  = odata_q[1*CW +: CW];
  assign rsp.out_z  = odata_q[2*CW +: CW];
  assign rsp.last   = olast_q;
  assign rsp.status = ostat_q;

  a_eval_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WGT || state_q == S_PT || state_q == S_DRAIN) |-> !ram_we)
    else $error("control point memory written during evaluation");

  a_wdone_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wdone |-> (state_q == S_WGT))
    else $error("weight unit finished outside its wait state");

  a_mac_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_PT || state_q == S_DRAIN))
    else $error("accumulator fed outside an evaluation");

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostat_q) |-> (olast_q && odata_q == '0))
    else $error("error result not final or not zero");

endmodule

// ===== tb/bcv_checker.sv =====
// Scoreboard of the cubic Bezier curve engine: mirrors the control points and the
// registers, predicts every response and compares it. Depends on bcv_pkg and bcv_if.
module bcv_checker import bcv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bcv_req_if                    req,
  bcv_rsp_if                    rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fails_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
    logic               status;
  } curve_rsp_t;

  logic signed [15:0] cp [16][4][3];
  logic [4:0]         seg_count;
  logic [6:0]         res_t;
  curve_rsp_t         rsp_q [$];

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic void enqueue_rsp(input curve_rsp_t r);
    rsp_q.insert(rsp_q.size(), r);
  endfunction

  function automatic longint round_sh(input longint acc, input int sh);
    return (acc + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic curve_rsp_t eval_pos(input int s, input longint t);
    longint u, w [4], acc;
    curve_rsp_t r;
    logic signed [15:0] c [3];
    u = 65536 - t;
    w[0] = (u * u * u) >>> 24;
    w[1] = (3 * u * u * t) >>> 24;
    w[2] = (3 * u * t * t) >>> 24;
    w[3] = (t * t * t) >>> 24;
    for (int a = 0; a < 3; a++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) acc += w[i] * longint'(cp[s][i][a]);
      c[a] = clamp16(round_sh(acc, POS_SHIFT));
    end
    r = '{c[0], c[1], c[2], 1'b1, 1'b0};
    return r;
  endfunction

  function automatic curve_rsp_t eval_vel(input int s, input longint t);
    longint u, w [3], acc;
    curve_rsp_t r;
    logic signed [15:0] c [3];
    u = 65536 - t;
    w[0] = (3 * u * u) >>> 16;
    w[1] = (6 * u * t) >>> 16;
    w[2] = (3 * t * t) >>> 16;
    for (int a = 0; a < 3; a++) begin
      acc = 0;
      for (int i = 0; i < 3; i++)
        acc += w[i] * (longint'(cp[s][i+1][a]) - longint'(cp[s][i][a]));
      c[a] = clamp16(round_sh(acc, VEL_SHIFT));
    end
    r = '{c[0], c[1], c[2], 1'b1, 1'b0};
    return r;
  endfunction

  task automatic apply_move(input int s, input int idx, input logic smooth, input int cnt,
                            input logic signed [15:0] np [3]);
    longint d [3];
    for (int a = 0; a < 3; a++) begin
      d[a] = longint'(np[a]) - longint'(cp[s][idx][a]);
      cp[s][idx][a] = np[a];
    end
    if (idx == 0 && s != 0) for (int a = 0; a < 3; a++) cp[s-1][3][a] = np[a];
    if (idx == 3 && s + 1 != cnt) for (int a = 0; a < 3; a++) cp[s+1][0][a] = np[a];
    // end handles of the curve have no neighbor to keep smooth
    if (!smooth || (s == 0 && idx < 2) || (s + 1 == cnt && idx > 1)) return;
    for (int a = 0; a < 3; a++) begin
      case (idx)
        0: begin
          cp[s-1][2][a] = clamp16(longint'(cp[s-1][2][a]) + d[a]);
          cp[s][1][a]   = clamp16(longint'(cp[s][1][a]) + d[a]);
        end
        1: cp[s-1][2][a] = clamp16(2 * longint'(cp[s-1][3][a]) - longint'(np[a]));
        2: cp[s+1][1][a] = clamp16(2 * longint'(cp[s][3][a]) - longint'(np[a]));
        default: begin
          cp[s+1][1][a] = clamp16(longint'(cp[s+1][1][a]) + d[a]);
          cp[s][2][a]   = clamp16(longint'(cp[s][2][a]) + d[a]);
        end
      endcase
    end
  endtask

  task automatic predict_request();
    int s, idx, cnt, n;
    logic signed [15:0] np [3];
    curve_rsp_t r;
    s   = req.segment;
    idx = req.point_index;
    cnt = (seg_count < 16) ? seg_count : 16;
    if (req.opcode > OP_TESS) return;
    if (s >= cnt) begin
      enqueue_rsp('{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1});
      return;
    end
    case (req.opcode)
      OP_MOVE, OP_READ: begin
        if (req.opcode == OP_MOVE) begin
          np[0] = req.new_x;
          np[1] = req.new_y;
          np[2] = req.new_z;
          apply_move(s, idx, req.keep_smooth, cnt, np);
        end
        enqueue_rsp('{cp[s][idx][0], cp[s][idx][1], cp[s][idx][2], 1'b1, 1'b0});
      end
      OP_POS: enqueue_rsp(eval_pos(s, longint'(req.t)));
      OP_VEL: enqueue_rsp(eval_vel(s, longint'(req.t)));
      default: begin
        n = (res_t == 0) ? 1 : ((res_t > MAX_POINTS) ? MAX_POINTS : res_t);
        for (int k = 0; k < n; k++) begin
          r = eval_pos(s, (longint'(k) * 65536) / n);
          r.last = (k + 1 == n);
          enqueue_rsp(r);
        end
      end
    endcase
  endtask

  initial begin
    fails_o   = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    curve_rsp_t got, want;
    if (!rst_ni) begin
      foreach (cp[i, j, a]) cp[i][j][a] = '0;
      seg_count = SEG_COUNT_RST;
      res_t     = RES_T_RST;
      rsp_q.delete();
    end else begin
      // responses belong to earlier requests: check them before predicting new ones
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.out_x, rsp.out_y, rsp.out_z, rsp.last, rsp.status};
        if (rsp_q.size() == 0) begin
          $display("%0t: unexpected response %p", $time, got);
          fails_o++;
        end else begin
          want = rsp_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fails_o++;
          end
        end
      end
      if (req.valid && req.ready) predict_request();
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SEG_COUNT) seg_count = cfg_data_i[4:0];
        else if (cfg_idx_i == CFG_RES_T) res_t = cfg_data_i[6:0];
      end
    end
    pending_o = rsp_q.size();
  end
endmodule

// ===== tb/testbench.sv =====
// Top of the curve engine testbench: clock, reset, request stimulus, response
// backpressure and verdict. Depends on bcv_pkg, bcv_if, bcv_checker and the engine.
module testbench;
  import bcv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 47;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fails, pending, cycles;
  int idle_pct, stall_pct, cur_segs;
  logic hold_go, holding;

  bcv_req_if req_if ();
  bcv_rsp_if #(.CW(16)) rsp_if ();

  cubic_bezier_curve_engine_top dut (
    .clk_i(clk), .rst_ni(rst_n), .req(req_if), .rsp(rsp_if),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  bcv_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .req(req_if), .rsp(rsp_if),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fails_o(fails), .pending_o(pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // long receiver hold-off, counted here while the sender keeps offering requests
  initial begin
    holding = 1'b0;
    wait (hold_go);
    @(negedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    holding <= 1'b0;
  end

  always @(negedge clk)
    rsp_if.ready <= !holding && ($urandom_range(99) >= stall_pct);

  task automatic send_req(input logic [2:0] op, input logic [3:0] seg, input logic [1:0] pi,
                          input logic ks, input logic [15:0] tv,
                          input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    @(negedge clk);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.segment     <= seg;
    req_if.point_index <= pi;
    req_if.keep_smooth <= ks;
    req_if.t           <= tv;
    req_if.new_x       <= x;
    req_if.new_y       <= y;
    req_if.new_z       <= z;
    #1;
    while (!req_if.ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
  endtask

  // drop valid, let every response drain, then let the block settle
  task automatic drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    if (idx == CFG_SEG_COUNT) cur_segs = (v[4:0] < 16) ? v[4:0] : 16;
  endtask

  function automatic logic [15:0] rand_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 16'h7fff;
    if (pick < 16) return 16'h8000;
    if (pick < 20) return 16'h0000;
    if (pick < 60) return 16'($urandom_range(2047)) - 16'd1024;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_t();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 16'h0000;
    if (pick < 16) return 16'hffff;
    return 16'($urandom);
  endfunction

  task automatic rand_req();
    int pick;
    logic [2:0] op;
    logic [3:0] seg;
    pick = $urandom_range(99);
    if (pick < 28) op = OP_MOVE;
    else if (pick < 44) op = OP_READ;
    else if (pick < 66) op = OP_POS;
    else if (pick < 88) op = OP_VEL;
    else if (pick < 96) op = OP_TESS;
    else op = 3'($urandom_range(OP_RSVD7, OP_RSVD5));
    if (cur_segs > 0 && $urandom_range(99) < 85) seg = 4'($urandom_range(cur_segs - 1));
    else seg = 4'($urandom);
    send_req(op, seg, 2'($urandom), 1'($urandom), rand_t(), rand_coord(), rand_coord(),
             rand_coord());
  endtask

  initial begin
    int seg_tab [7] = '{4, 16, 1, 0, 31, 16, 7};
    int res_tab [7] = '{4, 2, 64, 0, 127, 1, 3};
    idle_pct = 0;
    stall_pct = 0;
    cur_segs = 1;
    hold_go = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.opcode = '0;
    req_if.segment = '0;
    req_if.point_index = '0;
    req_if.keep_smooth = 1'b0;
    req_if.t = '0;
    req_if.new_x = '0;
    req_if.new_y = '0;
    req_if.new_z = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings first, then four segments
    send_req(OP_POS, 4'd0, 2'd0, 1'b0, 16'h8000, 16'h0, 16'h0, 16'h0);
    send_req(OP_READ, 4'd1, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    drain();
    write_reg(CFG_SEG_COUNT, 7'd4);
    write_reg(CFG_RES_T, 7'd4);
    send_req(OP_MOVE, 4'd0, 2'd0, 1'b1, 16'h0, 16'h7fff, 16'h8000, 16'h0100);
    send_req(OP_MOVE, 4'd1, 2'd0, 1'b1, 16'h0, 16'h8000, 16'h7fff, 16'hff00);
    send_req(OP_MOVE, 4'd1, 2'd3, 1'b1, 16'hffff, 16'h7fff, 16'h7fff, 16'h8000);
    send_req(OP_MOVE, 4'd3, 2'd3, 1'b1, 16'h0, 16'h0200, 16'hfe00, 16'h7fff);
    send_req(OP_MOVE, 4'd1, 2'd1, 1'b1, 16'h0, 16'h8000, 16'h0080, 16'h7fff);
    send_req(OP_MOVE, 4'd2, 2'd2, 1'b1, 16'h0, 16'h7fff, 16'h8000, 16'h0040);
    send_req(OP_MOVE, 4'd2, 2'd1, 1'b0, 16'h0, 16'h1234, 16'hedcb, 16'h0000);
    send_req(OP_MOVE, 4'd3, 2'd0, 1'b1, 16'h0, 16'h0300, 16'h0400, 16'hfb00);
    send_req(OP_READ, 4'd0, 2'd3, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_req(OP_READ, 4'd1, 2'd2, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_req(OP_POS, 4'd1, 2'd3, 1'b1, 16'h0000, 16'h0, 16'h0, 16'h0);
    send_req(OP_POS, 4'd1, 2'd0, 1'b0, 16'hffff, 16'h0, 16'h0, 16'h0);
    send_req(OP_POS, 4'd2, 2'd0, 1'b0, 16'h8000, 16'h0, 16'h0, 16'h0);
    send_req(OP_VEL, 4'd1, 2'd0, 1'b0, 16'h0000, 16'h0, 16'h0, 16'h0);
    send_req(OP_VEL, 4'd2, 2'd0, 1'b0, 16'hffff, 16'h0, 16'h0, 16'h0);
    send_req(OP_TESS, 4'd1, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_req(OP_MOVE, 4'd5, 2'd1, 1'b1, 16'h0, 16'h7fff, 16'h7fff, 16'h7fff);
    send_req(OP_READ, 4'd15, 2'd3, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_req(OP_POS, 4'd4, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_req(OP_VEL, 4'd15, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_req(OP_TESS, 4'd15, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_req(OP_RSVD5, 4'd0, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_req(OP_RSVD6, 4'd1, 2'd1, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_req(OP_RSVD7, 4'd2, 2'd2, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_SEG_COUNT, 7'(seg_tab[p]));
      write_reg(CFG_RES_T, 7'(res_tab[p]));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      if (p == 0) hold_go = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) rand_req();
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/bcv_pkg.sv
design/bcv_if.sv
design/bcv_ram.sv
design/bcv_wgt.sv
design/bcv_mac.sv
design/cubic_bezier_curve_engine_top.sv
tb/bcv_checker.sv
tb/testbench.sv
